FILE: rtl/core/u8rev_pkg.sv
`default_nettype none

package u8rev_pkg;

  // UTF-8 classification bounds (exclusive on both sides)
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_LO    = 8'hC1;
  localparam logic [7:0] LEAD2_HI    = 8'hE0;
  localparam logic [7:0] LEAD3_LO    = 8'hDF;
  localparam logic [7:0] LEAD3_HI    = 8'hF0;
  localparam logic [7:0] LEAD4_LO    = 8'hEF;
  localparam logic [7:0] LEAD4_HI    = 8'hF5;

  // command queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;

  // command kinds; a word with neither byte nor end is dropped at the front
  typedef enum logic [1:0] {
    CK_APPEND       = 2'd0,
    CK_FLUSH        = 2'd1,
    CK_APPEND_FLUSH = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    cmd_t  cmd;
  } q_head_t;

  // back end sequencer
  typedef enum logic [2:0] {
    BS_IDLE   = 3'd0,
    BS_PROBE0 = 3'd1,
    BS_PROBE1 = 3'd2,
    BS_PROBE2 = 3'd3,
    BS_PROBE3 = 3'd4,
    BS_PROBE4 = 3'd5,
    BS_EMIT   = 3'd6
  } back_state_t;

  function automatic logic is_lead2(input logic [7:0] b);
    return (b > LEAD2_LO) && (b < LEAD2_HI);
  endfunction

  function automatic logic is_lead3(input logic [7:0] b);
    return (b > LEAD3_LO) && (b < LEAD3_HI);
  endfunction

  function automatic logic is_lead4(input logic [7:0] b);
    return (b > LEAD4_LO) && (b < LEAD4_HI);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/u8rev_front.sv
`default_nettype none

module u8rev_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire  [7:0]           in_data_byte,
  input  wire                  in_byte_present,
  input  wire                  in_end_of_string,
  output u8rev_pkg::q_head_t   head_o,
  input  wire                  pop_i
);

  u8rev_pkg::cmd_t              q_r [u8rev_pkg::Q_DEPTH];
  logic [u8rev_pkg::Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [u8rev_pkg::Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [u8rev_pkg::Q_AW:0]     count_r, count_nxt;
  u8rev_pkg::cmd_t              cmd;
  logic                         cmd_valid;
  logic                         push;
  logic                         pop;

  // classify the incoming word
  always_comb begin
    cmd.data  = in_data_byte;
    cmd.kind  = u8rev_pkg::CK_APPEND;
    cmd_valid = 1'b1;
    case ({in_byte_present, in_end_of_string})
      2'b10:   cmd.kind = u8rev_pkg::CK_APPEND;
      2'b01:   cmd.kind = u8rev_pkg::CK_FLUSH;
      2'b11:   cmd.kind = u8rev_pkg::CK_APPEND_FLUSH;
      default: cmd_valid = 1'b0;
    endcase
  end

  assign busy = (count_r == (u8rev_pkg::Q_AW+1)'(u8rev_pkg::Q_DEPTH));
  assign push = start && !busy && cmd_valid;
  assign pop  = pop_i && (count_r != '0);

  assign head_o.valid = (count_r != '0);
  assign head_o.cmd   = q_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (u8rev_pkg::Q_AW+1)'(push) - (u8rev_pkg::Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (u8rev_pkg::Q_AW+1)'(u8rev_pkg::Q_DEPTH))
    else $error("queue count above depth");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not grow queue");

endmodule

`default_nettype wire

FILE: rtl/core/u8rev_back.sv
`default_nettype none

module u8rev_back #(
  parameter int unsigned MAX_BYTES = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  u8rev_pkg::q_head_t   head_i,
  output logic                 pop_o,
  output logic                 out_strobe,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output logic                 out_truncated
);

  localparam int unsigned AW = $clog2(MAX_BYTES);
  localparam int unsigned CW = $clog2(MAX_BYTES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BYTES);

  logic [7:0]              mem_r [MAX_BYTES];
  logic [7:0]              rdata_r;
  logic [AW-1:0]           raddr;
  logic                    wr_en;

  u8rev_pkg::back_state_t  state_r, state_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic [CW-1:0]           start_r, start_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  logic [7:0]              out_byte_r, out_byte_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_trunc_r, out_trunc_nxt;

  logic                    has_byte;
  logic                    has_end;
  logic                    wr_ok;
  logic [CW-1:0]           fill_after;
  logic                    dec_done;
  logic [2:0]              dec_len;
  logic [CW-1:0]           char_start;
  logic [CW-1:0]           pos_m1, pos_m2, pos_m3, pos_m4;
  logic [CW-1:0]           idx_p1;
  logic [CW-1:0]           start_m1;
  logic                    emit_final;

  // command decode
  always_comb begin
    has_byte = 1'b0;
    has_end  = 1'b0;
    case (head_i.cmd.kind)
      u8rev_pkg::CK_APPEND:       has_byte = 1'b1;
      u8rev_pkg::CK_FLUSH:        has_end  = 1'b1;
      u8rev_pkg::CK_APPEND_FLUSH: begin
        has_byte = 1'b1;
        has_end  = 1'b1;
      end
      default: begin
        has_byte = 1'b0;
        has_end  = 1'b0;
      end
    endcase
  end

  assign wr_ok      = has_byte && (fill_r != MAX_CNT);
  assign fill_after = fill_r + CW'(wr_ok);

  assign pos_m1     = pos_r - CW'(1);
  assign pos_m2     = pos_r - CW'(2);
  assign pos_m3     = pos_r - CW'(3);
  assign pos_m4     = pos_r - CW'(4);
  assign idx_p1     = idx_r + CW'(1);
  assign start_m1   = start_r - CW'(1);
  assign emit_final = (idx_r == pos_m1);
  assign char_start = pos_r - CW'(dec_len);

  // character length from the probed bytes, last byte at pos-1
  always_comb begin
    dec_done = 1'b0;
    dec_len  = 3'd1;
    case (state_r)
      u8rev_pkg::BS_PROBE1: begin
        if ((rdata_r < u8rev_pkg::ASCII_LIMIT) || (pos_r < CW'(2))) begin
          dec_done = 1'b1;
        end
      end
      u8rev_pkg::BS_PROBE2: begin
        if (u8rev_pkg::is_lead2(rdata_r)) begin
          dec_done = 1'b1;
          dec_len  = 3'd2;
        end else if (pos_r < CW'(3)) begin
          dec_done = 1'b1;
        end
      end
      u8rev_pkg::BS_PROBE3: begin
        if (u8rev_pkg::is_lead3(rdata_r)) begin
          dec_done = 1'b1;
          dec_len  = 3'd3;
        end else if (pos_r < CW'(4)) begin
          dec_done = 1'b1;
        end
      end
      u8rev_pkg::BS_PROBE4: begin
        dec_done = 1'b1;
        if (u8rev_pkg::is_lead4(rdata_r)) begin
          dec_len = 3'd4;
        end
      end
      default: begin
        dec_done = 1'b0;
        dec_len  = 3'd1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      u8rev_pkg::BS_IDLE: begin
        if (head_i.valid && has_end && (fill_after != '0)) begin
          state_nxt = u8rev_pkg::BS_PROBE0;
        end
      end
      u8rev_pkg::BS_PROBE0: state_nxt = u8rev_pkg::BS_PROBE1;
      u8rev_pkg::BS_PROBE1: state_nxt = dec_done ? u8rev_pkg::BS_EMIT : u8rev_pkg::BS_PROBE2;
      u8rev_pkg::BS_PROBE2: state_nxt = dec_done ? u8rev_pkg::BS_EMIT : u8rev_pkg::BS_PROBE3;
      u8rev_pkg::BS_PROBE3: state_nxt = dec_done ? u8rev_pkg::BS_EMIT : u8rev_pkg::BS_PROBE4;
      u8rev_pkg::BS_PROBE4: state_nxt = u8rev_pkg::BS_EMIT;
      u8rev_pkg::BS_EMIT: begin
        if (emit_final) begin
          state_nxt = (start_r == '0) ? u8rev_pkg::BS_IDLE : u8rev_pkg::BS_PROBE1;
        end
      end
      default: state_nxt = u8rev_pkg::BS_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop_o          = 1'b0;
    wr_en          = 1'b0;
    raddr          = '0;
    fill_nxt       = fill_r;
    ovf_nxt        = ovf_r;
    pos_nxt        = pos_r;
    start_nxt      = start_r;
    idx_nxt        = idx_r;
    out_strobe_nxt = 1'b0;
    out_byte_nxt   = rdata_r;
    out_last_nxt   = 1'b0;
    out_trunc_nxt  = ovf_r;
    case (state_r)
      u8rev_pkg::BS_IDLE: begin
        pop_o = head_i.valid;
        if (head_i.valid) begin
          wr_en   = wr_ok;
          ovf_nxt = ovf_r | (has_byte && !wr_ok);
          if (has_end) begin
            pos_nxt = fill_after;
            if (fill_after == '0) begin
              fill_nxt = '0;
              ovf_nxt  = 1'b0;
            end
          end else begin
            fill_nxt = fill_after;
          end
          if (has_end && (fill_after != '0)) begin
            fill_nxt = fill_after;
          end
        end
      end
      u8rev_pkg::BS_PROBE0: raddr = pos_m1[AW-1:0];
      u8rev_pkg::BS_PROBE1,
      u8rev_pkg::BS_PROBE2,
      u8rev_pkg::BS_PROBE3,
      u8rev_pkg::BS_PROBE4: begin
        if (dec_done) begin
          raddr     = char_start[AW-1:0];
          start_nxt = char_start;
          idx_nxt   = char_start;
        end else if (state_r == u8rev_pkg::BS_PROBE1) begin
          raddr = pos_m2[AW-1:0];
        end else if (state_r == u8rev_pkg::BS_PROBE2) begin
          raddr = pos_m3[AW-1:0];
        end else begin
          raddr = pos_m4[AW-1:0];
        end
      end
      u8rev_pkg::BS_EMIT: begin
        out_strobe_nxt = 1'b1;
        out_last_nxt   = emit_final && (start_r == '0);
        if (!emit_final) begin
          idx_nxt = idx_p1;
          raddr   = idx_p1[AW-1:0];
        end else begin
          pos_nxt = start_r;
          raddr   = start_m1[AW-1:0];
          if (start_r == '0) begin
            fill_nxt = '0;
            ovf_nxt  = 1'b0;
          end
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= u8rev_pkg::BS_IDLE;
      fill_r       <= '0;
      ovf_r        <= 1'b0;
      pos_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      ovf_r        <= ovf_nxt;
      pos_r        <= pos_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    start_r     <= start_nxt;
    idx_r       <= idx_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  // string buffer, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[fill_r[AW-1:0]] <= head_i.cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign out_strobe    = out_strobe_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;
  assign out_truncated = out_trunc_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= MAX_CNT)
    else $error("fill count above capacity");

  a_busy_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != u8rev_pkg::BS_IDLE) |-> (pos_r != '0))
    else $error("walk running with nothing left");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) == u8rev_pkg::BS_EMIT))
    else $error("result word outside emit");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_last_r) |-> ((fill_r == '0) && !ovf_r &&
                                      (state_r == u8rev_pkg::BS_IDLE)))
    else $error("state not cleared after last word");

endmodule

`default_nettype wire

FILE: rtl/core/utf8_string_reverser_core.sv
`default_nettype none

// UTF-8 string reverser. Bytes of a string come in one word per start pulse
// and go into a buffer of MAX_BYTES entries; bytes past capacity are dropped
// and flag out_truncated on every result word of that string. On the word
// with in_end_of_string set, the buffer is walked from the end and the
// characters come out in reverse order, each multi-byte sequence in its own
// byte order, one word per out_strobe pulse, the final one with out_last.
// The receiver cannot stall: every out_strobe word must be taken in that
// cycle. A two-entry queue sits in front of the buffer; busy goes high
// only when the queue is full during a reversal. The reversal is
// sequenced over a single-port read of the buffer: a start step for the
// walk, then per character a lookback over one to four probed bytes (one
// read per probed byte) to find its lead byte, then its bytes are emitted.
module utf8_string_reverser_core #(
  parameter int unsigned MAX_BYTES = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_byte_present,
  input  wire         in_end_of_string,
  output logic        out_strobe,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_truncated
);

  u8rev_pkg::q_head_t  head;
  logic                pop;

  u8rev_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_data_byte     (in_data_byte),
    .in_byte_present  (in_byte_present),
    .in_end_of_string (in_end_of_string),
    .head_o           (head),
    .pop_i            (pop)
  );

  u8rev_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_i        (head),
    .pop_o         (pop),
    .out_strobe    (out_strobe),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_truncated (out_truncated)
  );

endmodule

`default_nettype wire
